>>> hw/rtl/clm_pkg.sv
// ============================================================================
// clm_pkg: shared types for the circular linked list manager
// Request and response payloads, operation kinds, controller states and the
// command and status bundles between the controller and the datapath.
// ============================================================================
`default_nettype none

package clm_pkg;

    // Width of the entry index fields on the ports.
    localparam int ENTRY_W = 4;

    // Operation kinds carried in the request's kind field.
    typedef enum logic [2:0] {
        KIND_REMOVE      = 3'd0,
        KIND_REMOVE_HEAD = 3'd1,
        KIND_INS_AFTER   = 3'd2,
        KIND_INS_BEFORE  = 3'd3,
        KIND_ADD_HEAD    = 3'd4,
        KIND_ADD_TAIL    = 3'd5
    } kind_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic               list_select;
        logic [ENTRY_W-1:0] entry_index;
        logic [ENTRY_W-1:0] target_index;
    } req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] result_entry;
        logic               done_res;
        logic               misuse;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_STEP1,
        ST_STEP2
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic init_wr;
        logic load;
        logic step1;
        logic step2;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic init_last;
        logic slot_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/circular_linked_list_manager_top.sv
// ============================================================================
// circular_linked_list_manager_top: circular doubly linked list pool manager
// Keeps a pool of entries threaded into a free list and an allocated list,
// and removes, inserts and adds entries on request.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ----------------------------
//  req       in         req_valid / req_stall  kind, list, entry, target
//  rsp       out        rsp_valid / rsp_stall  result entry, done, misuse
//
// Each transaction reads the links of the entry and of its neighbor from the
// two link memories in the accepting cycle, then writes the link memories,
// which have one write port each, in two steps.
// After reset a clearing pass over all ENTRY_COUNT entries rebuilds the free list;
// req_stall stays high during it.
// The result sits in an output register, so a finished result waiting on
// rsp_stall does not hold off the next request; only the final write step
// of a later transaction waits for the output register to free up.
//
`default_nettype none

module circular_linked_list_manager_top #(
    parameter int ENTRY_COUNT = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire clm_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output clm_pkg::rsp_t      rsp
);

    // Command and status bundles between the sequencer and the datapath.
    clm_pkg::cmd_t cmd;
    clm_pkg::sts_t sts;

    // The sequencer owns the request handshake and step ordering.
    clm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath owns the link memories, list heads and result register.
    clm_datapath #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

>>> hw/rtl/clm_datapath.sv
// ============================================================================
// clm_datapath: link memories, list heads and result register
// Holds the next and prev link memories, the two list heads, the captured
// request and the output register, and performs the writes that the
// controller sequences.
// ============================================================================
`default_nettype none

module clm_datapath #(
    parameter int ENTRY_COUNT = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire clm_pkg::req_t req,
    input  wire clm_pkg::cmd_t cmd,
    output clm_pkg::sts_t      sts,
    input  wire logic          rsp_stall,
    output logic               rsp_valid,
    output clm_pkg::rsp_t      rsp
);

    localparam int ENT_W  = clm_pkg::ENTRY_W;
    localparam int LINK_W = $clog2(ENTRY_COUNT);
    localparam int IDX_W  = (LINK_W > ENT_W) ? LINK_W : ENT_W;
    localparam logic [IDX_W:0]    COUNT_V  = (IDX_W + 1)'(ENTRY_COUNT);
    localparam logic [LINK_W-1:0] LAST_IDX = LINK_W'(ENTRY_COUNT - 1);

    logic [LINK_W-1:0] next_mem [ENTRY_COUNT];
    logic [LINK_W-1:0] prev_mem [ENTRY_COUNT];

    logic [LINK_W-1:0] next_a_reg, prev_a_reg, next_b_reg, prev_b_reg;
    logic [LINK_W-1:0] rd_addr_a, rd_addr_b;

    logic              nx_we, pv_we;
    logic [LINK_W-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

    logic [2:0]        kind_reg;
    logic              lst_reg;
    logic [LINK_W-1:0] ent_reg, tgt_reg;
    logic [ENT_W-1:0]  res_reg;
    logic              ok_reg;

    logic [LINK_W-1:0] head_reg  [2];
    logic [LINK_W-1:0] head_next [2];
    logic [1:0]        present_reg, present_next;

    logic [LINK_W-1:0] init_cnt_reg, init_cnt_next;

    logic              out_valid_reg, out_valid_next;
    clm_pkg::rsp_t     out_reg;

    // Request decode, evaluated in the accepting cycle.
    logic [IDX_W-1:0]  e_wide, t_wide;
    logic              e_ok, t_ok, ok_d;
    logic [LINK_W-1:0] req_head;
    logic              req_present;
    logic [ENT_W-1:0]  res_d;

    assign e_wide      = IDX_W'(req.entry_index);
    assign t_wide      = IDX_W'(req.target_index);
    assign e_ok        = {1'b0, e_wide} < COUNT_V;
    assign t_ok        = {1'b0, t_wide} < COUNT_V;
    assign req_head    = head_reg[req.list_select];
    assign req_present = present_reg[req.list_select];

    always_comb
    begin
        ok_d      = 1'b0;
        rd_addr_a = LINK_W'(e_wide);
        rd_addr_b = LINK_W'(t_wide);
        res_d     = req.entry_index;
        case (req.kind)
            clm_pkg::KIND_REMOVE:
            begin
                ok_d = e_ok && req_present;
            end
            clm_pkg::KIND_REMOVE_HEAD:
            begin
                ok_d      = req_present;
                rd_addr_a = req_head;
                if (req_present)
                begin
                    res_d = ENT_W'(req_head);
                end
            end
            clm_pkg::KIND_INS_AFTER, clm_pkg::KIND_INS_BEFORE:
            begin
                ok_d = e_ok && t_ok;
            end
            clm_pkg::KIND_ADD_HEAD, clm_pkg::KIND_ADD_TAIL:
            begin
                ok_d      = e_ok;
                rd_addr_b = req_head;
            end
            default:
            begin
                ok_d = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req.kind;
            lst_reg  <= req.list_select;
            ent_reg  <= rd_addr_a;
            tgt_reg  <= rd_addr_b;
            res_reg  <= res_d;
            ok_reg   <= ok_d;
        end
    end

    // Operation decode on the captured request and the link snapshot.
    logic self_ok, lst_present, is_unlink, is_after, is_before, is_add;
    logic eff, misuse_d, unlink_en, after_en, before_en;

    assign self_ok     = (next_a_reg == ent_reg) && (prev_a_reg == ent_reg);
    assign lst_present = present_reg[lst_reg];
    assign is_unlink   = (kind_reg == clm_pkg::KIND_REMOVE)
                      || (kind_reg == clm_pkg::KIND_REMOVE_HEAD);
    assign is_after    = (kind_reg == clm_pkg::KIND_INS_AFTER);
    assign is_before   = (kind_reg == clm_pkg::KIND_INS_BEFORE);
    assign is_add      = (kind_reg == clm_pkg::KIND_ADD_HEAD)
                      || (kind_reg == clm_pkg::KIND_ADD_TAIL);
    assign eff         = ok_reg && (!is_add || self_ok);
    assign misuse_d    = is_add && ok_reg && !self_ok;
    assign unlink_en   = eff && is_unlink;
    assign after_en    = eff && is_after;
    // Adding to a present list splices in front of its head.
    assign before_en   = eff && (is_before || (is_add && lst_present));

    // Link memory write selection. Step one writes the entry's links or
    // its neighbors' bypass; step two splices it in or self-links it.
    always_comb
    begin
        nx_we = 1'b0;
        nx_wa = ent_reg;
        nx_wd = ent_reg;
        pv_we = 1'b0;
        pv_wa = ent_reg;
        pv_wd = ent_reg;
        if (cmd.init_wr)
        begin
            nx_we = 1'b1;
            nx_wa = init_cnt_reg;
            nx_wd = (init_cnt_reg == LAST_IDX) ? '0 : init_cnt_reg + 1'b1;
            pv_we = 1'b1;
            pv_wa = init_cnt_reg;
            pv_wd = (init_cnt_reg == '0) ? LAST_IDX : init_cnt_reg - 1'b1;
        end
        else if (cmd.step1)
        begin
            if (unlink_en)
            begin
                nx_we = 1'b1;
                nx_wa = prev_a_reg;
                nx_wd = next_a_reg;
                pv_we = 1'b1;
                pv_wa = next_a_reg;
                pv_wd = prev_a_reg;
            end
            else if (after_en)
            begin
                nx_we = 1'b1;
                nx_wd = next_b_reg;
                pv_we = 1'b1;
                pv_wd = tgt_reg;
            end
            else if (before_en)
            begin
                nx_we = 1'b1;
                nx_wd = tgt_reg;
                pv_we = 1'b1;
                pv_wd = prev_b_reg;
            end
        end
        else if (cmd.step2)
        begin
            if (unlink_en)
            begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            else if (after_en)
            begin
                nx_we = 1'b1;
                nx_wa = tgt_reg;
                pv_we = 1'b1;
                pv_wa = next_b_reg;
            end
            else if (before_en)
            begin
                nx_we = 1'b1;
                nx_wa = prev_b_reg;
                pv_we = 1'b1;
                pv_wa = tgt_reg;
            end
        end
    end

    // The link snapshot is taken in the accepting cycle and held through
    // both write steps, however long the second one waits.
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (cmd.load)
        begin
            next_a_reg <= next_mem[rd_addr_a];
            prev_a_reg <= prev_mem[rd_addr_a];
            next_b_reg <= next_mem[rd_addr_b];
            prev_b_reg <= prev_mem[rd_addr_b];
        end
    end

    // List heads change only in the second step.
    always_comb
    begin
        head_next    = head_reg;
        present_next = present_reg;
        if (cmd.step2)
        begin
            if (unlink_en && (head_reg[lst_reg] == ent_reg))
            begin
                if (ent_reg != next_a_reg)
                begin
                    head_next[lst_reg] = next_a_reg;
                end
                else
                begin
                    head_next[lst_reg]    = '0;
                    present_next[lst_reg] = 1'b0;
                end
            end
            if (eff && is_add
                && ((kind_reg == clm_pkg::KIND_ADD_HEAD) || !lst_present))
            begin
                head_next[lst_reg]    = ent_reg;
                present_next[lst_reg] = 1'b1;
            end
        end
    end

    assign init_cnt_next  = cmd.init_wr ? init_cnt_reg + 1'b1 : init_cnt_reg;
    assign out_valid_next = cmd.step2 ? 1'b1 : (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            present_reg   <= 2'b01;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            present_reg   <= present_next;
            init_cnt_reg  <= init_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step2)
        begin
            out_reg.result_entry <= res_reg;
            out_reg.done_res     <= eff;
            out_reg.misuse       <= misuse_d;
        end
    end

    assign sts.init_last = (init_cnt_reg == LAST_IDX);
    assign sts.slot_free = !out_valid_reg || !rsp_stall;
    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/clm_controller.sv
// ============================================================================
// clm_controller: operation sequencer
// Runs the link memory clearing pass after reset, then takes one request at
// a time through its read and two write steps.
// ============================================================================
`default_nettype none

module clm_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire clm_pkg::sts_t sts,
    output clm_pkg::cmd_t      cmd
);

    clm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clm_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            clm_pkg::ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.init_last)
                begin
                    state_next = clm_pkg::ST_IDLE;
                end
            end
            clm_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = clm_pkg::ST_STEP1;
                end
            end
            clm_pkg::ST_STEP1:
            begin
                cmd.step1  = 1'b1;
                state_next = clm_pkg::ST_STEP2;
            end
            clm_pkg::ST_STEP2:
            begin
                // The last write and the result load wait for a free slot.
                if (sts.slot_free)
                begin
                    cmd.step2  = 1'b1;
                    state_next = clm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clm_pkg::ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/clm_checker.sv
// ============================================================================
// clm_checker: port level checks for the list manager
// Watches the top level's ports and flags ordering and payload errors.
// ============================================================================
`default_nettype none

module clm_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire clm_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire clm_pkg::rsp_t rsp
);

    logic req_accept;

    assign req_accept = req_valid && !req_stall;

    // A stalled request stays valid and keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // A held response keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // A misuse report never claims the operation took effect.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.misuse && rsp.done_res))
        else $error("misuse and done both set");

    // Only one transaction is in flight: accepting closes the request side.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> req_stall)
        else $error("request taken while busy");

    // A new response is only produced while a transaction is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without a transaction in flight");

endmodule

bind circular_linked_list_manager_top clm_checker u_clm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

>>> verif/circular_linked_list_manager_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// circular_linked_list_manager_top_test: self-checking bench for the pool manager
// Drives removal, head removal, insertion and add transactions into the free
// and allocated lists. A behavioral copy of the link memories predicts every
// response, and each response is checked field by field in arrival order.
// ============================================================================

module circular_linked_list_manager_top_test;

    localparam int POOL_SIZE     = 16;
    localparam int RANDOM_ITEMS  = 275;     // per idling phase, four phases
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTED  = 10;
    localparam int NOISE_PCT     = 15;

    // Kind codes outside the defined operations; the block must ignore them.
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam logic LIST_FREE  = 1'b0;
    localparam logic LIST_ALLOC = 1'b1;

    typedef logic [clm_pkg::ENTRY_W-1:0] entry_t;

    // Complete link state of the pool: both link memories and both list heads.
    typedef struct packed {
        logic [POOL_SIZE-1:0][clm_pkg::ENTRY_W-1:0] nxt;
        logic [POOL_SIZE-1:0][clm_pkg::ENTRY_W-1:0] prv;
        logic [1:0][clm_pkg::ENTRY_W-1:0]           head;
        logic [1:0]                                 present;
    } pool_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    clm_pkg::req_t   req_data = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    clm_pkg::rsp_t   rsp_data;

    // Transactions waiting for the driver, and responses predicted but not yet seen.
    clm_pkg::req_t   pending_reqs[$];
    clm_pkg::rsp_t   expected_rsps[$];

    // The generator keeps its own copy of the pool so that it can build
    // well-formed sequences ahead of time; the checker's copy advances only
    // on accepted transactions.
    pool_t  gen_pool;
    pool_t  live_pool;

    int     free_members[$];
    int     alloc_members[$];
    int     loose_entries[$];

    int     sender_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     cycle_count = 0;
    int     error_count = 0;
    int     mismatch_count = 0;
    logic   req_taken = 1'b0;

    circular_linked_list_manager_top #(
        .ENTRY_COUNT (POOL_SIZE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // After reset every entry sits on the free list in index order, entry 0
    // at its head, and the allocated list is empty.
    function automatic pool_t reset_pool();
        pool_t p;
        p = '0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            p.nxt[i] = entry_t'((i + 1) % POOL_SIZE);
            p.prv[i] = entry_t'((i + POOL_SIZE - 1) % POOL_SIZE);
        end
        p.present = 2'b01;
        return p;
    endfunction

    // Takes an entry out of whatever ring it is on and leaves it linked to
    // itself. When the entry was the head, the head moves to its successor,
    // or the list becomes empty if the entry was alone.
    function automatic void unlink_entry(inout pool_t p, input logic l, input entry_t e);
        entry_t nx;
        entry_t pv;
        nx = p.nxt[e];
        pv = p.prv[e];
        p.nxt[pv] = nx;
        p.prv[nx] = pv;
        if (p.head[l] == e)
        begin
            if (e != nx)
            begin
                p.head[l] = nx;
            end
            else
            begin
                p.head[l] = '0;
                p.present[l] = 1'b0;
            end
        end
        p.nxt[e] = e;
        p.prv[e] = e;
    endfunction

    // The links are written one after another, each read seeing the previous
    // write, so that degenerate cases such as an entry spliced next to itself
    // come out the same way the hardware sequences them.
    function automatic void splice_before(inout pool_t p, input entry_t t, input entry_t e);
        p.nxt[e] = t;
        p.prv[e] = p.prv[t];
        p.nxt[p.prv[t]] = e;
        p.prv[t] = e;
    endfunction

    // Advances a pool by one transaction and returns the response it causes.
    function automatic clm_pkg::rsp_t apply_request(inout pool_t p, input clm_pkg::req_t r);
        clm_pkg::rsp_t o;
        entry_t        e;
        entry_t        t;
        logic          l;
        e = r.entry_index;
        t = r.target_index;
        l = r.list_select;
        o.result_entry = e;
        o.done_res = 1'b0;
        o.misuse = 1'b0;
        case (r.kind)
            clm_pkg::KIND_REMOVE:
            begin
                if (p.present[l])
                begin
                    unlink_entry(p, l, e);
                    o.done_res = 1'b1;
                end
            end
            clm_pkg::KIND_REMOVE_HEAD:
            begin
                if (p.present[l])
                begin
                    o.result_entry = p.head[l];
                    unlink_entry(p, l, p.head[l]);
                    o.done_res = 1'b1;
                end
            end
            clm_pkg::KIND_INS_AFTER:
            begin
                p.nxt[e] = p.nxt[t];
                p.prv[e] = t;
                p.prv[p.nxt[t]] = e;
                p.nxt[t] = e;
                o.done_res = 1'b1;
            end
            clm_pkg::KIND_INS_BEFORE:
            begin
                splice_before(p, t, e);
                o.done_res = 1'b1;
            end
            clm_pkg::KIND_ADD_HEAD, clm_pkg::KIND_ADD_TAIL:
            begin
                // Only an entry that is linked to itself may be added.
                if (p.nxt[e] != e || p.prv[e] != e)
                begin
                    o.misuse = 1'b1;
                end
                else
                begin
                    if (p.present[l])
                    begin
                        splice_before(p, p.head[l], e);
                    end
                    if (r.kind == clm_pkg::KIND_ADD_HEAD || !p.present[l])
                    begin
                        p.head[l] = e;
                        p.present[l] = 1'b1;
                    end
                    o.done_res = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic clm_pkg::req_t make_req(logic [2:0] k, logic l, entry_t e, entry_t t);
        clm_pkg::req_t r;
        r.kind = k;
        r.list_select = l;
        r.entry_index = e;
        r.target_index = t;
        return r;
    endfunction

    task automatic queue_request(input clm_pkg::req_t r);
        void'(apply_request(gen_pool, r));
        pending_reqs.push_back(r);
    endtask

    // Sorts the entries of the generator's pool into members of each ring
    // and self-linked loose entries. Entries stranded by malformed traffic
    // land in neither set and are simply not chosen by well-formed requests.
    task automatic survey_lists();
        logic [POOL_SIZE-1:0] seen;
        entry_t               cur;
        seen = '0;
        free_members.delete();
        alloc_members.delete();
        loose_entries.delete();
        for (int l = 0; l < 2; l++)
        begin
            if (gen_pool.present[l])
            begin
                cur = gen_pool.head[l];
                for (int step = 0; step < POOL_SIZE; step++)
                begin
                    if (l == 0)
                        free_members.push_back(int'(cur));
                    else
                        alloc_members.push_back(int'(cur));
                    seen[cur] = 1'b1;
                    cur = gen_pool.nxt[cur];
                    if (cur == gen_pool.head[l])
                        break;
                end
            end
        end
        for (int e = 0; e < POOL_SIZE; e++)
        begin
            if (!seen[e] && gen_pool.nxt[e] == entry_t'(e) && gen_pool.prv[e] == entry_t'(e))
                loose_entries.push_back(e);
        end
    endtask

    function automatic entry_t pick_member(logic l);
        if (l == LIST_FREE)
            return entry_t'(free_members[$urandom_range(free_members.size() - 1)]);
        return entry_t'(alloc_members[$urandom_range(alloc_members.size() - 1)]);
    endfunction

    function automatic entry_t pick_loose();
        return entry_t'(loose_entries[$urandom_range(loose_entries.size() - 1)]);
    endfunction

    // Most random transactions keep both rings intact: entries leave a ring
    // by removal and come back by add or splice while loose. The rest are
    // random fields, which exercise misuse and corrupted rings.
    task automatic build_random_request(output clm_pkg::req_t r);
        clm_pkg::kind_t op;
        logic           l;
        int             list_len;
        r.kind = 3'($urandom_range(5));
        r.list_select = 1'($urandom_range(1));
        r.entry_index = entry_t'($urandom_range(POOL_SIZE - 1));
        r.target_index = entry_t'($urandom_range(POOL_SIZE - 1));
        if ($urandom_range(99) >= NOISE_PCT)
        begin
            survey_lists();
            op = clm_pkg::kind_t'($urandom_range(5));
            l = r.list_select;
            if (op >= clm_pkg::KIND_INS_AFTER && loose_entries.size() == 0)
                op = clm_pkg::KIND_REMOVE_HEAD;
            if ((op == clm_pkg::KIND_INS_AFTER || op == clm_pkg::KIND_INS_BEFORE)
                && free_members.size() == 0 && alloc_members.size() == 0)
                op = clm_pkg::KIND_ADD_TAIL;
            list_len = (l == LIST_FREE) ? free_members.size() : alloc_members.size();
            r.kind = op;
            case (op)
                clm_pkg::KIND_REMOVE:
                begin
                    // On an empty list the entry stays random; nothing happens.
                    if (list_len != 0)
                        r.entry_index = pick_member(l);
                end
                clm_pkg::KIND_INS_AFTER, clm_pkg::KIND_INS_BEFORE:
                begin
                    if (list_len == 0)
                        l = !l;
                    r.list_select = l;
                    r.target_index = pick_member(l);
                    r.entry_index = pick_loose();
                end
                clm_pkg::KIND_ADD_HEAD, clm_pkg::KIND_ADD_TAIL:
                begin
                    r.entry_index = pick_loose();
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Driver: a new transaction goes out at the falling edge once the previous
    // one has been accepted, unless the sender decides to idle. A transaction
    // left waiting on req_stall keeps its payload. The response stall is drawn
    // every cycle, independently of anything the block does.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    req_data <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
        req_taken = 1'b0;
    end

    // Monitor: at each rising edge an accepted request advances the checker's
    // pool and queues its prediction, and an accepted response is compared
    // with the oldest prediction. The cycle counter guards against a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("circular_linked_list_manager_top_test: done, errors");
            $finish;
        end
        else
        begin
            if (rst_n && req_valid && !req_stall)
            begin
                expected_rsps.push_back(apply_request(live_pool, req_data));
                req_taken = 1'b1;
            end
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("unexpected response: entry %0d done %0b misuse %0b",
                                 rsp_data.result_entry, rsp_data.done_res, rsp_data.misuse);
                end
                else
                begin
                    clm_pkg::rsp_t want;
                    want = expected_rsps.pop_front();
                    if (rsp_data.result_entry !== want.result_entry
                        || rsp_data.done_res !== want.done_res
                        || rsp_data.misuse !== want.misuse)
                    begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED)
                            $display({"mismatch: expected entry %0d done %0b misuse %0b,",
                                      " got entry %0d done %0b misuse %0b"},
                                     want.result_entry, want.done_res, want.misuse,
                                     rsp_data.result_entry, rsp_data.done_res,
                                     rsp_data.misuse);
                    end
                end
            end
        end
    end

    // Stimulus: a directed opening from the reset state, then random traffic
    // in four idling phases, each drained before the next one starts.
    initial
    begin
        clm_pkg::req_t r;
        gen_pool = reset_pool();
        live_pool = reset_pool();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Removals on the empty allocated list change nothing.
        queue_request(make_req(clm_pkg::KIND_REMOVE_HEAD, LIST_ALLOC, 4'd0, 4'd0));
        queue_request(make_req(clm_pkg::KIND_REMOVE, LIST_ALLOC, 4'd5, 4'd15));
        // Entry 0 moves from the free list head to the allocated list.
        queue_request(make_req(clm_pkg::KIND_REMOVE_HEAD, LIST_FREE, 4'd9, 4'd0));
        queue_request(make_req(clm_pkg::KIND_ADD_TAIL, LIST_ALLOC, 4'd0, 4'd15));
        // Adding an entry that is still linked is flagged as misuse.
        queue_request(make_req(clm_pkg::KIND_ADD_HEAD, LIST_FREE, 4'd3, 4'd0));
        queue_request(make_req(clm_pkg::KIND_REMOVE, LIST_FREE, 4'd15, 4'd0));
        queue_request(make_req(clm_pkg::KIND_ADD_HEAD, LIST_ALLOC, 4'd15, 4'd0));
        // Splices next to targets at both ends of the index range.
        queue_request(make_req(clm_pkg::KIND_REMOVE, LIST_FREE, 4'd7, 4'd0));
        queue_request(make_req(clm_pkg::KIND_INS_AFTER, LIST_ALLOC, 4'd7, 4'd0));
        queue_request(make_req(clm_pkg::KIND_REMOVE, LIST_FREE, 4'd8, 4'd15));
        queue_request(make_req(clm_pkg::KIND_INS_BEFORE, LIST_ALLOC, 4'd8, 4'd15));
        // Spare kind codes are ignored.
        queue_request(make_req(KIND_SPARE_LO, LIST_ALLOC, 4'd15, 4'd15));
        queue_request(make_req(KIND_SPARE_HI, LIST_FREE, 4'd0, 4'd0));
        queue_request(make_req(clm_pkg::KIND_ADD_TAIL, LIST_ALLOC, 4'd15, 4'd3));
        // Drain the allocated list; the fourth head removal leaves it empty.
        repeat (4)
            queue_request(make_req(clm_pkg::KIND_REMOVE_HEAD, LIST_ALLOC, 4'd1, 4'd2));
        queue_request(make_req(clm_pkg::KIND_REMOVE, LIST_ALLOC, 4'd0, 4'd0));
        queue_request(make_req(clm_pkg::KIND_ADD_TAIL, LIST_FREE, 4'd15, 4'd0));
        queue_request(make_req(clm_pkg::KIND_ADD_HEAD, LIST_FREE, 4'd0, 4'd15));
        queue_request(make_req(clm_pkg::KIND_ADD_TAIL, LIST_ALLOC, 4'd7, 4'd0));
        queue_request(make_req(clm_pkg::KIND_INS_BEFORE, LIST_ALLOC, 4'd8, 4'd7));
        // Removing the allocated head moves the head to its successor.
        queue_request(make_req(clm_pkg::KIND_REMOVE, LIST_ALLOC, 4'd7, 4'd0));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                build_random_request(r);
                queue_request(r);
            end
            while (pending_reqs.size() != 0)
                @(posedge clk);
        end

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsps.size() != 0)
            error_count++;

        if (error_count == 0)
            $display("circular_linked_list_manager_top_test: done, clean");
        else
            $display("circular_linked_list_manager_top_test: done, errors");
        $finish;
    end

endmodule
